// ----- design/drtfl_pkg.sv -----
`default_nettype none
package drtfl_pkg;

    localparam int TableDepth = 1024;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int CountW     = AddrW + 1;
    localparam int KeyW       = 23;
    localparam int RateW      = 32;
    localparam int LimitW     = 31;
    localparam logic [LimitW-1:0] LimitReset = 31'd65536000;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADDATE = 3'd1,
        ST_NEG     = 3'd2,
        ST_LARGE   = 3'd3,
        ST_NOEARLY = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_EXIST_RD,
        S_EXIST_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RATE_RD,
        S_MUL,
        S_OUT
    } fsm_t;

    // One memory access request from the controller.
    typedef struct packed {
        logic             rd_en;
        logic [AddrW-1:0] rd_addr;
        logic             wr_en;
        logic [AddrW-1:0] wr_addr;
        logic [KeyW-1:0]  wr_key;
        logic [RateW-1:0] wr_rate;
    } mem_req_t;

    // True when year, month and day form a valid Gregorian date.
    function automatic logic date_valid(input logic [13:0] y, input logic [6:0] m,
                                        input logic [6:0] d);
        logic        leap;
        logic [4:0]  len;
        logic [26:0] scaled;
        logic [7:0]  cent;
        logic [13:0] cent_rem;
        // Whole centuries by reciprocal multiplication, exact for any 14-bit year.
        scaled   = 27'(y) * 27'd5243;
        cent     = scaled[26:19];
        cent_rem = y - 14'(14'(cent) * 14'd100);
        // A century year is a leap year only when its century count is a multiple of four.
        leap = (y[1:0] == 2'd0) && ((cent_rem != 14'd0) || (cent[1:0] == 2'd0));
        unique case (m)
            7'd2:                       len = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return (y <= 14'd9999) && (m >= 7'd1) && (m <= 7'd12)
            && (d >= 7'd1) && (d <= {2'b00, len});
    endfunction

endpackage
`default_nettype wire

// ----- design/drtfl_table.sv -----
`default_nettype none
module drtfl_table (
    input  wire logic                       clk,
    input  wire drtfl_pkg::mem_req_t        req,
    output logic [drtfl_pkg::KeyW-1:0]      rd_key,
    output logic [drtfl_pkg::RateW-1:0]     rd_rate
);
    import drtfl_pkg::*;

    logic [KeyW-1:0]  key_mem  [TableDepth];
    logic [RateW-1:0] rate_mem [TableDepth];

    // Single write port and single registered read port per memory.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            key_mem[req.wr_addr]  <= req.wr_key;
            rate_mem[req.wr_addr] <= req.wr_rate;
        end
        if (req.rd_en)
        begin
            rd_key  <= key_mem[req.rd_addr];
            rd_rate <= rate_mem[req.rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- design/dated_rate_table_floor_lookup_top.sv -----
`default_nettype none
// Sorted dated rate table. One request is handled at a time, and no new
// request is taken while a result waits to be collected. A query searches the
// sorted keys with up to 11 reads, each followed by a compare, then reads the
// rate of the last entry at or below its date and multiplies it by the amount,
// or reports that no earlier entry exists. An insert searches the same way and
// reads the found entry; if its date matches, that entry is overwritten, else
// every later entry is moved up by one and the new one is written. An insert
// of a new date into a full table ends after the search and that read, and a
// bad date or amount ends a request before any search. The table memory gives
// one read per cycle through a registered read port. The next request can be
// taken in the cycle after the result is taken.
module dated_rate_table_floor_lookup_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [13:0] year,
    input  wire logic [6:0]  month,
    input  wire logic [6:0]  day,
    input  wire logic signed [31:0] amount,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic signed [31:0] rate_used,
    output logic signed [63:0] product
);
    import drtfl_pkg::*;

    fsm_t state_reg, state_next;
    logic [LimitW-1:0] limit_reg;
    logic              kind_reg;
    logic [KeyW-1:0]   key_reg;
    logic              dok_reg;
    logic [RateW-1:0]  amt_reg;
    logic [CountW-1:0] count_reg, lo_reg, lo_next, hi_reg, hi_next, idx_reg, idx_next;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [RateW-1:0]  rate_reg;
    logic [63:0]       prod_reg;
    mem_req_t          req;
    logic [KeyW-1:0]   rd_key;
    logic [RateW-1:0]  rd_rate;
    logic [CountW-1:0] mid;
    logic              below;
    logic              fire;

    drtfl_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_key  (rd_key),
        .rd_rate (rd_rate)
    );

    assign fire      = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    // Strict compare for inserts, at-or-below for queries.
    assign below     = kind_reg ? (rd_key <= key_reg) : (rd_key < key_reg);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign rate_used = rate_reg;
    assign product   = prod_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (fire) state_next = S_CHECK;
            S_CHECK:
            begin
                if (!dok_reg || (kind_reg && (amt_reg[31]
                    || (amt_reg[30:0] > limit_reg))))
                    state_next = S_OUT;
                else
                    state_next = S_SRCH_RD;
            end
            S_SRCH_RD:   state_next = (lo_reg < hi_reg) ? S_SRCH_CMP
                                   : (kind_reg ? S_RATE_RD : S_EXIST_RD);
            S_SRCH_CMP:  state_next = S_SRCH_RD;
            S_EXIST_RD:  state_next = S_EXIST_CMP;
            S_EXIST_CMP:
            begin
                if (lo_reg < count_reg && rd_key == key_reg)
                    state_next = S_PUT;
                else if (count_reg == CountW'(TableDepth))
                    state_next = S_OUT;
                else if (idx_reg > lo_reg)
                    state_next = S_SHIFT_RD;
                else
                    state_next = S_PUT;
            end
            S_SHIFT_RD:  state_next = S_SHIFT_WR;
            S_SHIFT_WR:  state_next = (idx_reg - 1'b1 > lo_reg) ? S_SHIFT_RD : S_PUT;
            S_PUT:       state_next = S_OUT;
            S_RATE_RD:   state_next = (lo_reg == '0) ? S_OUT : S_MUL;
            S_MUL:       state_next = S_OUT;
            S_OUT:       state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Memory requests and search bounds.
    always_comb
    begin
        req      = '0;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    lo_next = '0;
                    hi_next = count_reg;
                end
            end
            S_SRCH_RD:
            begin
                req.rd_en   = (lo_reg < hi_reg);
                req.rd_addr = mid[AddrW-1:0];
            end
            S_SRCH_CMP:
            begin
                if (below) lo_next = mid + 1'b1;
                else       hi_next = mid;
            end
            S_EXIST_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = lo_reg[AddrW-1:0];
                idx_next    = count_reg;
            end
            S_SHIFT_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = AddrW'(idx_reg - 1'b1);
            end
            S_SHIFT_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg[AddrW-1:0];
                req.wr_key  = rd_key;
                req.wr_rate = rd_rate;
                idx_next    = idx_reg - 1'b1;
            end
            S_PUT:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = lo_reg[AddrW-1:0];
                req.wr_key  = key_reg;
                req.wr_rate = amt_reg;
            end
            S_RATE_RD:
            begin
                req.rd_en   = (lo_reg != '0);
                req.rd_addr = AddrW'(lo_reg - 1'b1);
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LimitReset;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) limit_reg <= cfg_wdata;
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_EXIST_CMP && !(lo_reg < count_reg && rd_key == key_reg)
                && count_reg != CountW'(TableDepth))
                count_reg <= count_reg + 1'b1;
            if (state_reg != S_OUT || !out_valid_reg || out_ready)
                state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        idx_reg <= idx_next;
        if (fire)
        begin
            kind_reg   <= kind;
            key_reg    <= {year[13:0], month[3:0], day[4:0]};
            dok_reg    <= date_valid(year, month, day);
            amt_reg    <= amount;
            status_reg <= ST_OK;
            rate_reg   <= '0;
            prod_reg   <= '0;
        end
        unique case (state_reg)
            S_CHECK:
            begin
                if (!dok_reg)
                    status_reg <= ST_BADDATE;
                else if (kind_reg && amt_reg[31])
                    status_reg <= ST_NEG;
                else if (kind_reg && amt_reg[30:0] > limit_reg)
                    status_reg <= ST_LARGE;
            end
            S_EXIST_CMP:
                if (!(lo_reg < count_reg && rd_key == key_reg)
                    && count_reg == CountW'(TableDepth))
                    status_reg <= ST_FULL;
            S_RATE_RD:
                if (lo_reg == '0) status_reg <= ST_NOEARLY;
            S_MUL:
            begin
                rate_reg <= rd_rate;
                prod_reg <= $signed(amt_reg) * $signed(rd_rate);
            end
            default: ;
        endcase
    end

    // The shift stage copies keys read in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT_WR |-> $past(state_reg) == S_SHIFT_RD)
        else $error("shift write without read");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(TableDepth))
        else $error("entry count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(product))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> product == '0 && rate_used == '0)
        else $error("error result carries data");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH_CMP |-> lo_reg < hi_reg)
        else $error("search compare with empty range");

endmodule
`default_nettype wire

// ----- sim/rate_table_checker.sv -----
`timescale 1ns / 1ps
module rate_table_checker
    import drtfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [13:0] year,
    input  logic [6:0]  month,
    input  logic [6:0]  day,
    input  logic [31:0] amount,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [31:0] rate_used,
    input  logic [63:0] product,
    output int          fail_count,
    output int          awaited,
    output int          checked
);

    typedef struct packed {
        status_t     st;
        logic [31:0] rate;
        logic [63:0] prod;
    } rate_result_t;

    rate_result_t      expected_results[$];
    logic [KeyW-1:0]   date_table[TableDepth];
    logic [RateW-1:0]  rate_table[TableDepth];
    int unsigned       n_entries;
    logic [LimitW-1:0] limit;

    initial
    begin
        fail_count = 0;
        awaited    = 0;
        checked    = 0;
    end

    // A calendar date is real when the day fits the month, with the Gregorian leap rule.
    function automatic bit date_is_real(int unsigned y, int unsigned m, int unsigned d);
        int unsigned days;
        bit          leap;
        leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        case (m)
            2:           days = leap ? 29 : 28;
            4, 6, 9, 11: days = 30;
            default:     days = 31;
        endcase
        return (y <= 9999) && (m >= 1) && (m <= 12) && (d >= 1) && (d <= days);
    endfunction

    // Number of stored dates below the key, or at or below it when or_equal is set.
    function automatic int unsigned dates_below(logic [KeyW-1:0] key, bit or_equal);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = n_entries;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (date_table[mid] < key || (or_equal && date_table[mid] == key))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // Applies one request to the table copy and returns the result it should give.
    function automatic rate_result_t predict_request(logic k, logic [13:0] y, logic [6:0] m,
                                                     logic [6:0] d, logic [31:0] amt);
        rate_result_t     res;
        logic [KeyW-1:0]  key;
        int unsigned      pos;
        longint           prod;
        res = '{st: ST_OK, rate: '0, prod: '0};
        key = {y[13:0], m[3:0], d[4:0]};
        if (!date_is_real(y, m, d))
            res.st = ST_BADDATE;
        else if (k == 1'b0)
        begin
            pos = dates_below(key, 1'b0);
            pos = dates_below(key, 1'b0) > 0 && date_table[pos - 1] == key ? pos - 1 : pos;
            if (pos < n_entries && date_table[pos] == key)
                rate_table[pos] = amt;
            else if (n_entries >= TableDepth)
                res.st = ST_FULL;
            else
            begin
                for (int i = n_entries; i > pos; i--)
                begin
                    date_table[i] = date_table[i - 1];
                    rate_table[i] = rate_table[i - 1];
                end
                date_table[pos] = key;
                rate_table[pos] = amt;
                n_entries++;
            end
        end
        else if (amt[31])
            res.st = ST_NEG;
        else if (amt[30:0] > limit)
            res.st = ST_LARGE;
        else
        begin
            pos = dates_below(key, 1'b1);
            if (pos == 0)
                res.st = ST_NOEARLY;
            else
            begin
                res.rate = rate_table[pos - 1];
                prod     = longint'(signed'(amt)) * longint'(signed'(res.rate));
                res.prod = prod;
            end
        end
        return res;
    endfunction

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    endtask

    // Results are checked before new requests are queued, so an empty queue
    // on a result always means an unexpected result.
    always @(posedge clk or negedge rst_n)
    begin
        rate_result_t want;
        if (!rst_n)
        begin
            limit     = LimitReset;
            n_entries = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_results.size() == 0)
                    report_field("unexpected result, status", 64'hx, status);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.st)
                        report_field("status", want.st, status);
                    if (rate_used !== want.rate)
                        report_field("rate_used", want.rate, rate_used);
                    if (product !== want.prod)
                        report_field("product", want.prod, product);
                end
            end
            if (cfg_we)
                limit = cfg_wdata;
            if (in_valid && in_ready)
                expected_results.push_back(predict_request(kind, year, month, day, amount));
        end
        awaited = expected_results.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import drtfl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [30:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [31:0] amount;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] rate_used;
    logic [63:0] product;
    int          fail_count;
    int          awaited;
    int          checked;
    int          sent;
    int          burst_left;
    int          stall_mode;
    int          stall_left;
    logic [30:0] cur_limit;

    dated_rate_table_floor_lookup_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .year      (year),
        .month     (month),
        .day       (day),
        .amount    (amount),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .rate_used (rate_used),
        .product   (product)
    );

    rate_table_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .year       (year),
        .month      (month),
        .day        (day),
        .amount     (amount),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .rate_used  (rate_used),
        .product    (product),
        .fail_count (fail_count),
        .awaited    (awaited),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end

    // The receiver switches between always ready, coin-toss and long stalls.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        case (stall_mode)
            0:       out_ready = 1'b1;
            1:       out_ready = 1'($urandom_range(0, 1));
            default: out_ready = ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic int unsigned days_in(int unsigned y, int unsigned m);
        if (m == 2)
            return ((y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0))) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Sends one request and holds it until accepted; bursts end in a random gap.
    task automatic send(logic k, int unsigned y, int unsigned m, int unsigned d,
                        logic [31:0] a);
        @(negedge clk);
        in_valid = 1'b1;
        kind     = k;
        year     = 14'(y);
        month    = 7'(m);
        day      = 7'(d);
        amount   = a;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // The limit is only changed once every outstanding result has come back.
    task automatic set_limit(logic [30:0] v);
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        cur_limit = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // One random request: mostly real dates from a narrow range so queries hit.
    task automatic send_random();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        logic        k;
        logic [31:0] a;
        int          pick;
        k = ($urandom_range(0, 99) >= 35);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            y = 0;
        else if (pick == 1)
            y = 9999;
        else
            y = $urandom_range(1999, 2004);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, days_in(y, m));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            y = $urandom_range(0, 16383);
        else if (pick == 1)
            m = $urandom_range(0, 127);
        else if (pick == 2)
            d = (d % 2) ? 0 : $urandom_range(days_in(y, m) + 1, 127);
        a = $urandom;
        if (k)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                a = $urandom_range(0, cur_limit);
            else if (pick < 78)
                a = {1'b0, cur_limit};
            else if (pick < 85)
                a = {1'b0, cur_limit} + 32'd1;
            else if (pick < 93)
                a[31] = 1'b1;
        end
        send(k, y, m, d, a);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        kind       = 1'b0;
        year       = '0;
        month      = '0;
        day        = '0;
        amount     = '0;
        out_ready  = 1'b0;
        sent       = 0;
        burst_left = 0;
        stall_left = 0;
        cur_limit  = LimitReset;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests: empty table, leap rules, date limits, amount limits.
        send(1'b1, 2000, 6, 1, 32'h0001_0000);
        send(1'b0, 2000, 2, 29, 32'h0001_0000);
        send(1'b0, 1900, 2, 29, 32'h0002_0000);
        send(1'b0, 2023, 2, 29, 32'h0002_0000);
        send(1'b0, 2024, 2, 29, 32'h0003_0000);
        send(1'b1, 1999, 1, 1, 32'h0001_0000);
        send(1'b0, 10000, 1, 1, 32'h0001_0000);
        send(1'b0, 16383, 127, 127, 32'hFFFF_FFFF);
        send(1'b0, 2001, 0, 10, 32'h0001_0000);
        send(1'b0, 2001, 13, 10, 32'h0001_0000);
        send(1'b0, 2001, 1, 0, 32'h0001_0000);
        send(1'b0, 2001, 1, 32, 32'h0001_0000);
        send(1'b0, 2001, 4, 31, 32'h0001_0000);
        send(1'b0, 2001, 4, 30, 32'h8000_0000);
        send(1'b0, 0, 1, 1, 32'h7FFF_FFFF);
        send(1'b0, 9999, 12, 31, 32'hFFFF_FFFF);
        send(1'b0, 2000, 2, 29, 32'h0002_8000);
        send(1'b1, 1999, 12, 31, 32'h0000_0000);
        send(1'b1, 2000, 3, 1, 32'hFFFF_FFFF);
        send(1'b1, 2002, 5, 5, {1'b0, LimitReset});
        send(1'b1, 2002, 5, 5, {1'b0, LimitReset} + 1);
        send(1'b1, 2002, 5, 5, 32'h8000_0000);
        send(1'b1, 2001, 2, 29, 32'hFFFF_FFFF);
        send(1'b1, 9999, 12, 31, {1'b0, LimitReset});

        // Random requests under four limit settings, the extremes among them.
        repeat (140) send_random();
        set_limit('0);
        repeat (120) send_random();
        set_limit(31'h7FFF_FFFF);
        repeat (140) send_random();
        set_limit(31'($urandom_range(1, 31'h7FFF_FFFF)));
        repeat (120) send_random();

        @(negedge clk);
        in_valid = 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Sent %0d requests, inserts, overwrites and queries mixed; %0d results checked.",
                 sent, checked);
        $display("Limits covered: reset value, zero, maximum and a random value.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
